@@ hw/rtl/pf_pkg.sv @@
// Types and constants shared by the Playfair digraph cipher RTL.
// No dependencies; compiled first.
package pf_pkg;

	localparam int unsigned SIDE  = 5;
	localparam int unsigned CELLS = SIDE * SIDE;

	typedef logic [4:0] letter_t;
	typedef logic [2:0] coord_t;
	typedef logic [CELLS-1:0] cell_vec_t;
	typedef logic [49:0] cfg_data_t;

	localparam letter_t LETTER_I   = 5'd8;
	localparam letter_t LETTER_J   = 5'd9;
	localparam letter_t LETTER_MAX = 5'd25;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_CELLS_LOW  = 2'd0,
		REG_CELLS_MID  = 2'd1,
		REG_CELLS_HIGH = 2'd2
	} cfg_reg_t;

	// One step round the square, forwards or backwards
	function automatic coord_t step_mod5(input coord_t v, input logic back);
		coord_t r;
		if (back) begin
			r = (v == 3'd0) ? 3'd4 : v - 3'd1;
		end else begin
			r = (v == 3'd4) ? 3'd0 : v + 3'd1;
		end
		return r;
	endfunction

	// One-hot cell select from row and column
	function automatic cell_vec_t cell_sel(input coord_t row, input coord_t col);
		cell_vec_t s;
		s = '0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				if (row == coord_t'(r) && col == coord_t'(c)) begin
					s[r*SIDE + c] = 1'b1;
				end
			end
		end
		return s;
	endfunction

endpackage

@@ hw/rtl/pf_if.sv @@
// Valid/ready channel interfaces for the Playfair digraph cipher.
// Depends on pf_pkg.
interface pf_in_if;
	logic             valid;
	logic             ready;
	logic             func;
	pf_pkg::letter_t  first_letter;
	pf_pkg::letter_t  second_letter;

	modport source (output valid, func, first_letter, second_letter, input ready);
	modport sink   (input valid, func, first_letter, second_letter, output ready);
endinterface

interface pf_out_if;
	logic             valid;
	logic             ready;
	pf_pkg::letter_t  first_out;
	pf_pkg::letter_t  second_out;
	logic             not_found;

	modport source (output valid, first_out, second_out, not_found, input ready);
	modport sink   (input valid, first_out, second_out, not_found, output ready);
endinterface

interface pf_cfg_if;
	logic               valid;
	logic               ready;
	logic [1:0]         index;
	pf_pkg::cfg_data_t  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/playfair_digraph_cipher.sv @@
// Playfair digraph cipher, 5x5 key square in configuration registers.
// Throughput one item per cycle while the result side keeps taking results.
// Four register stages: compare, locate, rule, cell select; each stalls only when full.
// arst_n clears all valid bits and the key square (all cells read as letter a).
// Depends on pf_pkg and the channel interfaces in pf_if.sv.
module playfair_digraph_cipher (
	input  logic      clk,
	input  logic      arst_n,
	pf_in_if.sink     req,
	pf_out_if.source  rsp,
	pf_cfg_if.sink    cfg
);
	import pf_pkg::*;

	// ---------------------------------------------------------------
	// Key square: 25 cells, row-major; written from the config channel
	// ---------------------------------------------------------------
	letter_t cell_q [CELLS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CELLS; k++) cell_q[k] <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CELLS_LOW: begin
					for (int k = 0; k < 10; k++) cell_q[k] <= cfg.data[5*k +: 5];
				end
				REG_CELLS_MID: begin
					for (int k = 0; k < 10; k++) cell_q[10 + k] <= cfg.data[5*k +: 5];
				end
				REG_CELLS_HIGH: begin
					for (int k = 0; k < 5; k++) cell_q[20 + k] <= cfg.data[5*k +: 5];
				end
				default: ; // writes beyond the register list are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stall control: a stage moves when it is empty or its successor moves
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || rsp.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: fold j to i, compare each letter against all 25 cells
	// ---------------------------------------------------------------
	letter_t   a_fold, b_fold;
	cell_vec_t match_a, match_b;

	always_comb begin
		a_fold = (req.first_letter  == LETTER_J) ? LETTER_I : req.first_letter;
		b_fold = (req.second_letter == LETTER_J) ? LETTER_I : req.second_letter;
		for (int k = 0; k < CELLS; k++) begin
			// codes above z never match, even against a cell holding that code
			match_a[k] = (cell_q[k] == a_fold) && (a_fold <= LETTER_MAX);
			match_b[k] = (cell_q[k] == b_fold) && (b_fold <= LETTER_MAX);
		end
	end

	logic      func_s1;
	cell_vec_t match_a_s1, match_b_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1    <= req.func;
			match_a_s1 <= match_a;
			match_b_s1 <= match_b;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: last match in row-major order -> row and column
	// ---------------------------------------------------------------
	coord_t ra, ca, rb, cb;
	logic   hit_a, hit_b;

	always_comb begin
		ra = '0; ca = '0; rb = '0; cb = '0;
		hit_a = 1'b0; hit_b = 1'b0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				if (match_a_s1[r*SIDE + c]) begin
					ra = coord_t'(r); ca = coord_t'(c); hit_a = 1'b1;
				end
				if (match_b_s1[r*SIDE + c]) begin
					rb = coord_t'(r); cb = coord_t'(c); hit_b = 1'b1;
				end
			end
		end
	end

	logic   func_s2, found_s2;
	coord_t ra_s2, ca_s2, rb_s2, cb_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			func_s2  <= func_s1;
			found_s2 <= hit_a && hit_b;
			ra_s2    <= ra;
			ca_s2    <= ca;
			rb_s2    <= rb;
			cb_s2    <= cb;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: Playfair rule -> one-hot target cell per letter
	// Same row (also same cell) wins over same column; else rectangle corners.
	// ---------------------------------------------------------------
	coord_t na_r, na_c, nb_r, nb_c;

	always_comb begin
		if (ra_s2 == rb_s2) begin
			na_r = ra_s2; na_c = step_mod5(ca_s2, func_s2);
			nb_r = rb_s2; nb_c = step_mod5(cb_s2, func_s2);
		end else if (ca_s2 == cb_s2) begin
			na_r = step_mod5(ra_s2, func_s2); na_c = ca_s2;
			nb_r = step_mod5(rb_s2, func_s2); nb_c = cb_s2;
		end else begin
			na_r = ra_s2; na_c = cb_s2;
			nb_r = rb_s2; nb_c = ca_s2;
		end
	end

	logic      nf_s3;
	cell_vec_t sel_a_s3, sel_b_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			nf_s3    <= !found_s2;
			// an empty select gives zero letters for a missing letter
			sel_a_s3 <= found_s2 ? cell_sel(na_r, na_c) : '0;
			sel_b_s3 <= found_s2 ? cell_sel(nb_r, nb_c) : '0;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: one-hot AND-OR select of the cell contents, output register
	// ---------------------------------------------------------------
	letter_t out_a, out_b;

	always_comb begin
		out_a = '0;
		out_b = '0;
		for (int k = 0; k < CELLS; k++) begin
			out_a = out_a | (cell_q[k] & {5{sel_a_s3[k]}});
			out_b = out_b | (cell_q[k] & {5{sel_b_s3[k]}});
		end
	end

	letter_t first_out_s4, second_out_s4;
	logic    nf_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			first_out_s4  <= out_a;
			second_out_s4 <= out_b;
			nf_s4         <= nf_s3;
		end
	end

	assign rsp.valid      = v_s4;
	assign rsp.first_out  = first_out_s4;
	assign rsp.second_out = second_out_s4;
	assign rsp.not_found  = nf_s4;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_sel_a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !nf_s3 |-> $onehot(sel_a_s3))
		else $error("first letter target not one-hot");

	a_sel_b_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !nf_s3 |-> $onehot(sel_b_s3))
		else $error("second letter target not one-hot");

	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && nf_s4 |-> first_out_s4 == '0 && second_out_s4 == '0)
		else $error("missing letter gave non-zero result");

	a_s2_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en3 |=> v_s3)
		else $error("item lost between stage 2 and stage 3");

endmodule

@@ tb/sv/playfair_digraph_cipher_test.sv @@
// Self-checking testbench for playfair_digraph_cipher: directed digraphs, then random
// digraphs over several key squares, with random stalls on both channels.
// Depends on pf_pkg and the channel interfaces in pf_if.sv.
`timescale 1ns / 1ps

module playfair_digraph_cipher_test;
	import pf_pkg::*;

	// Direction codes carried on func
	localparam logic DIR_ENC = 1'b0;
	localparam logic DIR_DEC = 1'b1;

	// How a key square for a phase is made up
	typedef enum int {
		SQ_ALPHA,     // a..z without j, row-major
		SQ_SHUFFLED,  // the same 25 letters in random order
		SQ_MESSY,     // random cells: repeats, gaps, codes above z
		SQ_UNIFORM    // one letter in every cell
	} sq_style_t;

	// One result item as the block returns it
	typedef struct packed {
		letter_t first_out;
		letter_t second_out;
		logic    not_found;
	} digraph_res_t;

	logic clk;
	logic arst_n;

	pf_in_if  req_if ();
	pf_out_if rsp_if ();
	pf_cfg_if cfg_if ();

	playfair_digraph_cipher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// Shadow copy of the key registers, updated when a write is accepted
	logic [49:0] key_low;
	logic [49:0] key_mid;
	logic [24:0] key_high;

	// Square that the random stimulus draws letters from
	letter_t cur_sq [25];

	digraph_res_t expected_digraphs [$];

	bit idle_on;   // random gaps on both channels when set
	int rsp_hold;  // one-off long stall for the result side, in cycles
	int errors;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Generous ceiling: a correct run needs a small fraction of this
	initial begin
		#400_000;
		$display("playfair_digraph_cipher_test NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// Cell k of the square, row-major, as stored
	function automatic letter_t key_cell(int k);
		letter_t v;
		if (k < 10) begin
			v = key_low[5*k +: 5];
		end else if (k < 20) begin
			v = key_mid[5*(k-10) +: 5];
		end else begin
			v = key_high[5*(k-20) +: 5];
		end
		return v;
	endfunction

	// j looks up as i, codes above z never match; the last matching cell wins
	function automatic bit find_cell(letter_t code, output int pos);
		letter_t want;
		bit hit;
		want = (code == LETTER_J) ? LETTER_I : code;
		hit = 1'b0;
		pos = 0;
		if (want <= LETTER_MAX) begin
			for (int k = 0; k < CELLS; k++) begin
				if (key_cell(k) == want) begin
					pos = k;
					hit = 1'b1;
				end
			end
		end
		return hit;
	endfunction

	function automatic digraph_res_t playfair_transform(logic dir, letter_t a, letter_t b);
		digraph_res_t res;
		int pa, pb, ra, ca, rb, cb, sh, tmp;
		bit fa, fb;
		res = '0;
		fa = find_cell(a, pa);
		fb = find_cell(b, pb);
		if (!(fa && fb)) begin
			res.not_found = 1'b1;
		end else begin
			// a step back is four steps forward round the square
			sh = (dir == DIR_DEC) ? SIDE - 1 : 1;
			ra = pa / SIDE;
			ca = pa % SIDE;
			rb = pb / SIDE;
			cb = pb % SIDE;
			if (ra == rb) begin
				// same row, identical letters included
				ca = (ca + sh) % SIDE;
				cb = (cb + sh) % SIDE;
			end else if (ca == cb) begin
				ra = (ra + sh) % SIDE;
				rb = (rb + sh) % SIDE;
			end else begin
				// rectangle: swap columns
				tmp = ca;
				ca = cb;
				cb = tmp;
			end
			res.first_out  = key_cell(ra * SIDE + ca);
			res.second_out = key_cell(rb * SIDE + cb);
		end
		return res;
	endfunction

	// ---------------------------------------------------------------- drivers

	// Sends one digraph; returns at the accepting edge with valid still high,
	// so a following item can go out back to back.
	task automatic send_digraph(input logic dir, input letter_t a, input letter_t b);
		int gap;
		@(negedge clk);
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.func          <= dir;
		req_if.first_letter  <= a;
		req_if.second_letter <= b;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		expected_digraphs.push_back(playfair_transform(dir, a, b));
	endtask

	task automatic req_release();
		@(negedge clk);
		req_if.valid <= 1'b0;
	endtask

	// Input side quiet and every result back: the pipe is empty
	task automatic wait_idle();
		req_release();
		while (expected_digraphs.size() != 0) @(negedge clk);
	endtask

	task automatic load_key_reg(input cfg_reg_t idx, input logic [49:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		case (idx)
			REG_CELLS_LOW:  key_low  = val;
			REG_CELLS_MID:  key_mid  = val;
			REG_CELLS_HIGH: key_high = val[24:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic load_square(input letter_t sq [25]);
		logic [49:0] lo, mi, hi;
		lo = '0;
		mi = '0;
		hi = '0;
		for (int k = 0; k < 10; k++) begin
			lo[5*k +: 5] = sq[k];
			mi[5*k +: 5] = sq[k+10];
		end
		for (int k = 0; k < 5; k++) hi[5*k +: 5] = sq[k+20];
		// bits above the 25 used ones must be dropped by the block
		hi[49:25] = 25'($urandom);
		load_key_reg(REG_CELLS_LOW, lo);
		load_key_reg(REG_CELLS_MID, mi);
		load_key_reg(REG_CELLS_HIGH, hi);
	endtask

	function automatic void make_square(sq_style_t style);
		int code, j;
		letter_t t;
		code = 0;
		for (int k = 0; k < CELLS; k++) begin
			if (code == LETTER_J) code++;
			cur_sq[k] = letter_t'(code);
			code++;
		end
		case (style)
			SQ_SHUFFLED: begin
				for (int k = CELLS - 1; k > 0; k--) begin
					j = $urandom_range(0, k);
					t = cur_sq[k];
					cur_sq[k] = cur_sq[j];
					cur_sq[j] = t;
				end
			end
			SQ_MESSY: begin
				for (int k = 0; k < CELLS; k++) begin
					cur_sq[k] = ($urandom_range(0, 7) == 0) ? letter_t'($urandom_range(0, 31))
					                                        : letter_t'($urandom_range(0, 25));
				end
			end
			SQ_UNIFORM: begin
				t = letter_t'($urandom_range(0, 25));
				for (int k = 0; k < CELLS; k++) cur_sq[k] = t;
			end
			default: ;
		endcase
	endfunction

	// Mostly letters taken from the square, biased to same row and same column,
	// with j for i now and then; a tenth of the letters are raw 5-bit noise.
	task automatic send_random_digraph();
		int pa, pb;
		letter_t a, b;
		pa = $urandom_range(0, CELLS - 1);
		case ($urandom_range(0, 3))
			0:       pb = (pa / SIDE) * SIDE + $urandom_range(0, SIDE - 1);
			1:       pb = pa % SIDE + SIDE * $urandom_range(0, SIDE - 1);
			default: pb = $urandom_range(0, CELLS - 1);
		endcase
		a = cur_sq[pa];
		b = cur_sq[pb];
		if (a == LETTER_I && $urandom_range(0, 1)) a = LETTER_J;
		if (b == LETTER_I && $urandom_range(0, 1)) b = LETTER_J;
		if ($urandom_range(0, 9) == 0) a = letter_t'($urandom_range(0, 31));
		if ($urandom_range(0, 9) == 0) b = letter_t'($urandom_range(0, 31));
		send_digraph(logic'($urandom_range(0, 1)), a, b);
	endtask

	// ---------------------------------------------------------------- result side

	// Draws a stall per item, takes one result, checks it against the oldest prediction
	initial begin
		int stall;
		digraph_res_t got, want;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				stall = rsp_hold;
				rsp_hold = 0;
			end else begin
				stall = idle_on ? $urandom_range(0, 3) : 0;
			end
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
			got = '{rsp_if.first_out, rsp_if.second_out, rsp_if.not_found};
			if (expected_digraphs.size() == 0) begin
				$display("%0t: unexpected result item %0d %0d nf=%0b",
				         $time, got.first_out, got.second_out, got.not_found);
				errors++;
			end else begin
				want = expected_digraphs.pop_front();
				if (got.first_out !== want.first_out) begin
					$display("%0t: first_out expected %0d, got %0d",
					         $time, want.first_out, got.first_out);
					errors++;
				end
				if (got.second_out !== want.second_out) begin
					$display("%0t: second_out expected %0d, got %0d",
					         $time, want.second_out, got.second_out);
					errors++;
				end
				if (got.not_found !== want.not_found) begin
					$display("%0t: not_found expected %0b, got %0b",
					         $time, want.not_found, got.not_found);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// Square straight out of reset: every cell holds a
	task automatic test_reset_square();
		send_digraph(DIR_ENC, 5'd0, 5'd0);   // last match is the corner, wraps to cell 20
		send_digraph(DIR_DEC, 5'd0, 5'd0);
		send_digraph(DIR_ENC, 5'd1, 5'd0);   // b absent
		send_digraph(DIR_DEC, 5'd0, 5'd9);   // j looks up as i, absent
	endtask

	// Row, column and rectangle rules on the plain alphabet square
	task automatic test_direct_rules();
		wait_idle();
		make_square(SQ_ALPHA);
		load_square(cur_sq);
		send_digraph(DIR_ENC, 5'd0, 5'd4);   // a e: same row, wraps right
		send_digraph(DIR_DEC, 5'd0, 5'd4);   // wraps left
		send_digraph(DIR_ENC, 5'd0, 5'd21);  // a v: same column, wraps down
		send_digraph(DIR_DEC, 5'd0, 5'd21);  // wraps up
		send_digraph(DIR_ENC, 5'd1, 5'd19);  // b t: rectangle
		send_digraph(DIR_DEC, 5'd1, 5'd19);
		send_digraph(DIR_ENC, 5'd4, 5'd4);   // identical letters shift along the row
		send_digraph(DIR_DEC, 5'd4, 5'd4);
	endtask

	task automatic test_special_cases();
		send_digraph(DIR_ENC, 5'd9, 5'd25);  // j folded to i
		send_digraph(DIR_DEC, 5'd8, 5'd9);   // i and j land on one cell
		send_digraph(DIR_ENC, 5'd26, 5'd0);  // code above z
		send_digraph(DIR_ENC, 5'd0, 5'd31);
		send_digraph(DIR_DEC, 5'd31, 5'd25);
		send_digraph(DIR_ENC, 5'd25, 5'd25);
	endtask

	// All-ones and all-zero register contents
	task automatic test_register_extremes();
		wait_idle();
		load_key_reg(REG_CELLS_LOW, '1);
		load_key_reg(REG_CELLS_MID, '1);
		load_key_reg(REG_CELLS_HIGH, '1);
		send_digraph(DIR_ENC, 5'd0, 5'd0);   // every cell is 31: nothing matches
		send_digraph(DIR_DEC, 5'd25, 5'd31);
		wait_idle();
		load_key_reg(REG_CELLS_LOW, '0);
		load_key_reg(REG_CELLS_MID, '0);
		load_key_reg(REG_CELLS_HIGH, '0);
		send_digraph(DIR_ENC, 5'd0, 5'd0);
	endtask

	// Long result stall with the sender flat out, so the pipe fills and
	// input ready drops; then a full drain before going on.
	task automatic test_backpressure();
		wait_idle();
		make_square(SQ_SHUFFLED);
		load_square(cur_sq);
		idle_on = 1'b0;
		rsp_hold = 40;
		repeat (30) send_random_digraph();
		wait_idle();
		idle_on = 1'b1;
		repeat (20) send_random_digraph();
	endtask

	task automatic test_random_squares();
		sq_style_t style;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				1, 3, 6: style = SQ_MESSY;
				4:       style = SQ_UNIFORM;
				default: style = SQ_SHUFFLED;
			endcase
			wait_idle();
			make_square(style);
			load_square(cur_sq);
			// one phase runs with no gaps on either side
			idle_on = (ph != 2);
			repeat (200) send_random_digraph();
		end
		idle_on = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.func = DIR_ENC;
		req_if.first_letter = '0;
		req_if.second_letter = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_CELLS_LOW;
		cfg_if.data = '0;
		key_low = '0;
		key_mid = '0;
		key_high = '0;
		idle_on = 1'b1;
		rsp_hold = 0;
		errors = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_square();
		test_direct_rules();
		test_special_cases();
		test_register_extremes();
		test_backpressure();
		test_random_squares();

		req_release();
		for (int n = 0; n < 2000 && expected_digraphs.size() != 0; n++) @(posedge clk);
		if (expected_digraphs.size() != 0) begin
			$display("%0t: %0d result items never arrived", $time, expected_digraphs.size());
			errors++;
		end
		// keep watching the result side to catch any stray item behind the last one
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("playfair_digraph_cipher_test OK");
		end else begin
			$display("playfair_digraph_cipher_test NOT OK");
		end
		$finish;
	end

endmodule
